// File: hw/rtl/assert_macros.svh
// assertion macros used by ocp_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent in a cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/ocp_pkg.sv
// types, constants and sine table of the orbit camera block
`default_nettype none
package ocp_pkg;

    localparam int ANGLE_BITS         = 16;
    localparam int SINE_TABLE_ENTRIES = 256;
    localparam int SINE_IDX_BITS      = $clog2(SINE_TABLE_ENTRIES);
    localparam int SINE_BITS          = 17;
    localparam int CFG_IDX_BITS       = 3;
    localparam int S_TDATA_BITS       = 120;
    localparam int M_TDATA_BITS       = 192;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    localparam logic [CFG_IDX_BITS-1:0] REG_ORBIT_DISTANCE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_TURN_RATE      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_MAX      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_MIN      = 3'd4;

    localparam logic [23:0]        RST_ORBIT_DISTANCE = 24'd1280;
    localparam logic signed [31:0] RST_TARGET_HEIGHT  = 32'sd0;
    localparam logic [15:0]        RST_TURN_RATE      = 16'd256;
    localparam logic signed [15:0] RST_PITCH_MAX      = 16'sd16384;
    localparam logic signed [15:0] RST_PITCH_MIN      = -16'sd16384;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_LOOK,
        ST_MUL1,
        ST_MUL2,
        ST_OUT
    } ocp_state_t;

    typedef struct packed {
        logic load_in;
        logic step_angle;
        logic step_look;
        logic step_mul1;
        logic step_mul2;
        logic out_load;
    } ocp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } ocp_status_t;

    typedef logic signed [SINE_BITS-1:0] sine_tab_t [SINE_TABLE_ENTRIES];

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t         tab;
        logic [63:0]       t;
        logic [63:0]       r;
        logic [63:0]       x;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic signed [63:0] sum;
        logic [1:0]        quad;
        for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
            t    = (64'(i) << (32 - SINE_IDX_BITS)) & 64'hFFFF_FFFF;
            quad = t[31:30];
            r    = {34'd0, t[29:0]};
            if (quad[0]) begin
                r = 64'h4000_0000 - r;
            end
            x    = (r * HALF_PI_Q30) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            if (sum < 0) begin
                sum = 64'sd0;
            end
            sum = (sum + 64'sd16384) >>> 15;
            tab[i] = quad[1] ? -SINE_BITS'(sum) : SINE_BITS'(sum);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage
`default_nettype wire

// File: hw/rtl/ocp_ctrl.sv
// sequencing state machine of the orbit camera block
`default_nettype none
`include "assert_macros.svh"
module ocp_ctrl (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  ocp_pkg::ocp_status_t status,
    output ocp_pkg::ocp_cmd_t   cmd
);
    import ocp_pkg::*;

    ocp_state_t state_reg;
    ocp_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_ANGLE;
            end
            ST_ANGLE: state_next = ST_LOOK;
            ST_LOOK:  state_next = ST_MUL1;
            ST_MUL1:  state_next = ST_MUL2;
            ST_MUL2:  state_next = ST_OUT;
            ST_OUT: begin
                if (!status.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_ANGLE: cmd.step_angle = 1'b1;
            ST_LOOK:  cmd.step_look  = 1'b1;
            ST_MUL1:  cmd.step_mul1  = 1'b1;
            ST_MUL2:  cmd.step_mul2  = 1'b1;
            ST_OUT:   cmd.out_load   = !status.out_busy;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    `ASSERT_NEXT(a_accept_starts, aclk, aresetn, s_tvalid && s_tready, state_reg == ST_ANGLE)
    `ASSERT_NEXT(a_mul2_to_out, aclk, aresetn, state_reg == ST_MUL2, state_reg == ST_OUT)
    `ASSERT_SAME(a_load_free, aclk, aresetn, cmd.out_load, !status.out_busy && !s_tready)
endmodule
`default_nettype wire

// File: hw/rtl/ocp_datapath.sv
// registers, table lookups and multipliers of the orbit camera block
`default_nettype none
module ocp_datapath (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  ocp_pkg::ocp_cmd_t                cmd,
    output ocp_pkg::ocp_status_t             status,
    input  wire [ocp_pkg::S_TDATA_BITS-1:0]  s_tdata,
    input  wire [1:0]                        s_tuser,
    input  wire                              cfg_valid,
    input  wire [ocp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire [31:0]                       cfg_data,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [ocp_pkg::M_TDATA_BITS-1:0] m_tdata
);
    import ocp_pkg::*;

    logic [23:0]                   dist_reg;
    logic signed [31:0]            height_reg;
    logic [15:0]                   turn_reg;
    logic signed [15:0]            pmax_reg;
    logic signed [15:0]            pmin_reg;

    logic [ANGLE_BITS-1:0]         yaw_reg;
    logic signed [15:0]            pitch_reg;
    logic signed [31:0]            aim_x_reg;
    logic signed [31:0]            aim_y_reg;
    logic signed [31:0]            aim_z_reg;

    logic signed [11:0]            dx_reg;
    logic signed [11:0]            dy_reg;
    logic                          freeze_reg;
    logic                          has_tgt_reg;
    logic signed [31:0]            fx_reg;
    logic signed [31:0]            fy_reg;
    logic signed [31:0]            fz_reg;

    logic signed [SINE_BITS-1:0]   sp_reg;
    logic signed [SINE_BITS-1:0]   cp_reg;
    logic signed [SINE_BITS-1:0]   sy_reg;
    logic signed [SINE_BITS-1:0]   cy_reg;
    logic signed [33:0]            pa_reg;
    logic signed [33:0]            pb_reg;
    logic signed [41:0]            py_reg;
    logic signed [57:0]            px_reg;
    logic signed [57:0]            pz_reg;
    logic                          m_tvalid_reg;
    logic [M_TDATA_BITS-1:0]       m_tdata_reg;

    logic signed [28:0]            yaw_prod;
    logic signed [28:0]            pitch_prod;
    logic signed [20:0]            dyaw;
    logic signed [21:0]            p_sum;
    logic signed [15:0]            pitch_next;
    logic [ANGLE_BITS-1:0]         yaw_next;
    logic signed [32:0]            fy_sum;
    logic signed [31:0]            fy_sat;
    logic [ANGLE_BITS-1:0]         pphase;
    logic [ANGLE_BITS-1:0]         yphase;
    logic [ANGLE_BITS-1:0]         pphase_cos;
    logic [ANGLE_BITS-1:0]         yphase_cos;
    logic signed [24:0]            dist_s;
    logic signed [57:0]            ox_full;
    logic signed [57:0]            oz_full;
    logic signed [41:0]            oy_full;
    logic signed [27:0]            ox;
    logic signed [27:0]            oy;
    logic signed [27:0]            oz;
    logic signed [33:0]            ex_sum;
    logic signed [33:0]            ey_sum;
    logic signed [33:0]            ez_sum;

    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            return 32'sh8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg   <= RST_ORBIT_DISTANCE;
            height_reg <= RST_TARGET_HEIGHT;
            turn_reg   <= RST_TURN_RATE;
            pmax_reg   <= RST_PITCH_MAX;
            pmin_reg   <= RST_PITCH_MIN;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_ORBIT_DISTANCE: dist_reg   <= cfg_data[23:0];
                REG_TARGET_HEIGHT:  height_reg <= cfg_data;
                REG_TURN_RATE:      turn_reg   <= cfg_data[15:0];
                REG_PITCH_MAX:      pmax_reg   <= cfg_data[15:0];
                REG_PITCH_MIN:      pmin_reg   <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // angle step
    assign yaw_prod   = dx_reg * $signed({1'b0, turn_reg});
    assign pitch_prod = dy_reg * $signed({1'b0, turn_reg});
    assign dyaw       = 21'(yaw_prod >>> 8);
    assign p_sum      = 22'(pitch_reg) + 22'(pitch_prod >>> 8);
    assign yaw_next   = yaw_reg - ANGLE_BITS'(dyaw);

    // upper clamp first, then lower clamp; pmin wins if the limits cross; held while frozen
    always_comb begin
        pitch_next = pitch_reg;
        if (!freeze_reg) begin
            if (p_sum >= 22'(pmax_reg)) begin
                pitch_next = (pmax_reg <= pmin_reg) ? pmin_reg : pmax_reg;
            end else if (p_sum <= 22'(pmin_reg)) begin
                pitch_next = pmin_reg;
            end else begin
                pitch_next = p_sum[15:0];
            end
        end
    end

    assign fy_sum = 33'(fy_reg) + 33'(height_reg);
    assign fy_sat = sat34(34'(fy_sum));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            yaw_reg   <= '0;
            pitch_reg <= '0;
            aim_x_reg <= '0;
            aim_y_reg <= '0;
            aim_z_reg <= '0;
        end else if (cmd.step_angle) begin
            if (!freeze_reg) begin
                yaw_reg <= yaw_next;
            end
            pitch_reg <= pitch_next;
            if (has_tgt_reg) begin
                aim_x_reg <= fx_reg;
                aim_y_reg <= fy_sat;
                aim_z_reg <= fz_reg;
            end else begin
                aim_y_reg <= height_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            dx_reg      <= s_tdata[11:0];
            dy_reg      <= s_tdata[23:12];
            fx_reg      <= s_tdata[55:24];
            fy_reg      <= s_tdata[87:56];
            fz_reg      <= s_tdata[119:88];
            freeze_reg  <= s_tuser[0];
            has_tgt_reg <= s_tuser[1];
        end
    end

    // table lookups
    assign pphase     = ANGLE_BITS'(pitch_reg);
    assign yphase     = yaw_reg;
    assign pphase_cos = pphase + QUARTER_TURN;
    assign yphase_cos = yphase + QUARTER_TURN;

    always_ff @(posedge aclk) begin
        if (cmd.step_look) begin
            sp_reg <= SINE_TAB[pphase[ANGLE_BITS-1 -: SINE_IDX_BITS]];
            cp_reg <= SINE_TAB[pphase_cos[ANGLE_BITS-1 -: SINE_IDX_BITS]];
            sy_reg <= SINE_TAB[yphase[ANGLE_BITS-1 -: SINE_IDX_BITS]];
            cy_reg <= SINE_TAB[yphase_cos[ANGLE_BITS-1 -: SINE_IDX_BITS]];
        end
    end

    // products
    assign dist_s = $signed({1'b0, dist_reg});

    always_ff @(posedge aclk) begin
        if (cmd.step_mul1) begin
            pa_reg <= 34'(sy_reg) * 34'(cp_reg);
            pb_reg <= 34'(cy_reg) * 34'(cp_reg);
            py_reg <= 42'(sp_reg) * 42'(dist_s);
        end
        if (cmd.step_mul2) begin
            px_reg <= 58'(pa_reg) * 58'(dist_s);
            pz_reg <= 58'(pb_reg) * 58'(dist_s);
        end
    end

    // rounding and saturated sums
    assign ox_full = px_reg + (58'sd1 <<< 29);
    assign oz_full = -pz_reg + (58'sd1 <<< 29);
    assign oy_full = py_reg + (42'sd1 <<< 14);
    assign ox      = 28'(ox_full >>> 30);
    assign oz      = 28'(oz_full >>> 30);
    assign oy      = 28'(oy_full >>> 15);
    assign ex_sum  = 34'(aim_x_reg) + 34'(ox);
    assign ey_sum  = 34'(aim_y_reg) + 34'(oy);
    assign ez_sum  = 34'(aim_z_reg) + 34'(oz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {aim_z_reg, aim_y_reg, aim_x_reg,
                            sat34(ez_sum), sat34(ey_sum), sat34(ex_sum)};
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.out_busy = m_tvalid_reg && !m_tready;
endmodule
`default_nettype wire

// File: hw/rtl/orbit_camera_position.sv
// top level of the orbit camera position block
// usage:
//   s channel: one beat per rendered frame; tdata holds mouse_dx, mouse_dy,
//   followed_x, followed_y, followed_z; tuser holds freeze and has_target
//   m channel: one beat per input beat with eye_x/y/z and aim_x/y/z
//   cfg channel: index and data write, always ready, used while idle
// sequence: from the accepting edge, m_tvalid is reached through the
//   state sequence angle update, table lookup, two multiply steps and
//   the output load
// input: a beat is taken only in the idle state, after the last result is loaded;
//   the next input beat may be taken while a result still waits in the
//   output register
// reset: aresetn low clears the angles, the stored target and the output
//   valid, and restores the configuration defaults
// receiver stall: the finished result waits in the output register and
//   the next result is held back until that beat has been taken
`default_nettype none
module orbit_camera_position (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    // mouse_dx, mouse_dy, followed_x, followed_y, followed_z
    input  wire [ocp_pkg::S_TDATA_BITS-1:0]  s_tdata,
    // freeze, has_target
    input  wire [1:0]                        s_tuser,
    output logic                             m_tvalid,
    input  wire                              m_tready,
    // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z
    output logic [ocp_pkg::M_TDATA_BITS-1:0] m_tdata,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [ocp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire [31:0]                       cfg_data
);
    import ocp_pkg::*;

    ocp_cmd_t    cmd;
    ocp_status_t status;

    assign cfg_ready = 1'b1;

    ocp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ocp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );
endmodule
`default_nettype wire
